// ===== rtl/core/leg2d_pkg.sv =====
// Package: shared widths, constants and fixed-point helpers for the 2D Legendre basis unit.
package leg2d_pkg;

  localparam int FRAC     = 16;
  localparam int MAX_ORD  = 5;
  localparam int CW       = 18;            // coordinate width
  localparam int LW       = 24;            // 1D value/derivative width (Q7.16 signed)
  localparam int GW       = 48;

  localparam logic [1:0] REG_ORDER   = 2'd0;
  localparam logic [1:0] REG_SCALE_X = 2'd1;
  localparam logic [1:0] REG_SCALE_Y = 2'd2;

  localparam logic signed [LW-1:0] SQ3 = 24'sd113512;
  localparam logic signed [LW-1:0] SQ5 = 24'sd146543;
  localparam logic signed [LW-1:0] SQ7 = 24'sd173392;

  // one-dimensional values and derivatives for degrees 0..4
  typedef struct packed {
    logic signed [4:0][LW-1:0] l;
    logic signed [4:0][LW-1:0] d;
  } leg1d_t;

  // Signed multiply, shift right by FRAC, round half away from zero (narrow operands).
  function automatic logic signed [47:0] rmul(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
    logic signed [47:0] p;
    logic [47:0] u;
    begin
      p = a * b;
      u = p[47] ? 48'(-p) : 48'(p);
      u = (u + 48'd32768) >> FRAC;
      rmul = p[47] ? -$signed(u) : $signed(u);
    end
  endfunction

  // degree pair per basis index
  function automatic logic [2:0] deg_i(input logic [4:0] k);
    case (k)
      5'd1, 5'd3, 5'd7, 5'd12, 5'd19: deg_i = 3'd1;
      5'd4, 5'd6, 5'd8, 5'd14, 5'd21: deg_i = 3'd2;
      5'd9, 5'd11, 5'd13, 5'd15, 5'd23: deg_i = 3'd3;
      5'd16, 5'd18, 5'd20, 5'd22, 5'd24: deg_i = 3'd4;
      default: deg_i = 3'd0;
    endcase
  endfunction

  function automatic logic [2:0] deg_j(input logic [4:0] k);
    case (k)
      5'd2, 5'd3, 5'd6, 5'd11, 5'd18: deg_j = 3'd1;
      5'd5, 5'd7, 5'd8, 5'd13, 5'd20: deg_j = 3'd2;
      5'd10, 5'd12, 5'd14, 5'd15, 5'd22: deg_j = 3'd3;
      5'd17, 5'd19, 5'd21, 5'd23, 5'd24: deg_j = 3'd4;
      default: deg_j = 3'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/leg2d_poly.sv =====
// Module: four-stage pipeline computing normalized 1D Legendre values and derivatives.
module leg2d_poly (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [leg2d_pkg::CW-1:0] x,
  output leg2d_pkg::leg1d_t             res
);
  localparam int W = leg2d_pkg::LW;
  typedef logic signed [W-1:0] s_t;

  s_t xc, x1_r, x2_r, x1b_r, x2b_r, x3_r, x4_r;
  s_t a_r, b_r, c_r, e_r, f_r;
  s_t l1_r, d2_r;
  leg2d_pkg::leg1d_t res_r;

  always_comb begin
    if (x > 18'sd65536)       xc = s_t'(65536);
    else if (x < -18'sd65536) xc = s_t'(-65536);
    else                      xc = s_t'(x);
  end

  // stage 1: square
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= xc;
      x2_r <= s_t'(leg2d_pkg::rmul(xc, xc));
    end
  end

  // stage 2: cube, fourth power, linear terms
  always_ff @(posedge clk) begin
    if (en) begin
      x1b_r <= x1_r;
      x2b_r <= x2_r;
      x3_r  <= s_t'(leg2d_pkg::rmul(x2_r, x1_r));
      x4_r  <= s_t'(leg2d_pkg::rmul(x2_r, x2_r));
    end
  end

  // stage 3: coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      l1_r  <= s_t'(leg2d_pkg::rmul(leg2d_pkg::SQ3, x1b_r));
      d2_r  <= s_t'(leg2d_pkg::rmul(leg2d_pkg::SQ5, s_t'(3 * x1b_r)));
      a_r   <= s_t'(leg2d_pkg::rmul(s_t'(12 <<< 13), x2b_r) - (4 <<< 13));
      b_r   <= s_t'(leg2d_pkg::rmul(s_t'(20 <<< 13), x3_r)
                    - leg2d_pkg::rmul(s_t'(12 <<< 13), x1b_r));
      c_r   <= s_t'(leg2d_pkg::rmul(s_t'(60 <<< 13), x2b_r) - (12 <<< 13));
      e_r   <= s_t'(leg2d_pkg::rmul(s_t'(105 <<< 13), x4_r)
                    - leg2d_pkg::rmul(s_t'(90 <<< 13), x2b_r) + (9 <<< 13));
      f_r   <= s_t'(leg2d_pkg::rmul(s_t'(420 <<< 13), x3_r)
                    - leg2d_pkg::rmul(s_t'(180 <<< 13), x1b_r));
    end
  end

  // stage 4: scale by sqrt constants
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.l[0] <= s_t'(65536);
      res_r.d[0] <= '0;
      res_r.l[1] <= l1_r;
      res_r.d[1] <= leg2d_pkg::SQ3;
      res_r.l[2] <= s_t'(leg2d_pkg::rmul(leg2d_pkg::SQ5, a_r));
      res_r.d[2] <= d2_r;
      res_r.l[3] <= s_t'(leg2d_pkg::rmul(leg2d_pkg::SQ7, b_r));
      res_r.d[3] <= s_t'(leg2d_pkg::rmul(leg2d_pkg::SQ7, c_r));
      res_r.l[4] <= e_r;
      res_r.d[4] <= f_r;
    end
  end

  assign res = res_r;
endmodule

// ===== rtl/core/leg2d_tens.sv =====
// Module: one basis value and two scaled, saturated gradients per enabled cycle.
module leg2d_tens (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [leg2d_pkg::LW-1:0]   li,
  input  logic signed [leg2d_pkg::LW-1:0]   di,
  input  logic signed [leg2d_pkg::LW-1:0]   lj,
  input  logic signed [leg2d_pkg::LW-1:0]   dj,
  input  logic [31:0]                       sx,
  input  logic [31:0]                       sy,
  output logic signed [20:0]                value,
  output logic signed [leg2d_pkg::GW-1:0]   gx,
  output logic signed [leg2d_pkg::GW-1:0]   gy
);
  localparam int W = leg2d_pkg::LW;
  logic signed [W-1:0] v_r, px_r, py_r;
  logic [31:0] sx_r, sy_r;
  logic signed [20:0] val_r, val2_r;
  logic signed [leg2d_pkg::GW-1:0] gx_r, gy_r, gx2_r, gy2_r;

  // scale product: |p| * s, round, saturate to 48 bits signed
  function automatic logic signed [47:0] gmul(input logic signed [W-1:0] p,
                                              input logic [31:0] s);
    logic [W-1:0] u;
    logic [63:0] m;
    logic [47:0] r;
    begin
      u = p[W-1] ? W'(-p) : W'(p);
      m = u * s;
      m = (m + 64'd32768) >> 16;
      r = (m > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : m[47:0];
      gmul = p[W-1] ? -$signed(r) : $signed(r);
    end
  endfunction

  // stage 1: tensor products; stage 2: scaled gradients; stage 3: output registers
  always_ff @(posedge clk) begin
    if (en) begin
      v_r  <= W'(leg2d_pkg::rmul(li, lj));
      px_r <= W'(leg2d_pkg::rmul(di, lj));
      py_r <= W'(leg2d_pkg::rmul(li, dj));
      sx_r <= sx;
      sy_r <= sy;
      gx_r <= gmul(px_r, sx_r);
      gy_r <= gmul(py_r, sy_r);
      val_r  <= 21'(v_r);
      val2_r <= val_r;
      gx2_r  <= gx_r;
      gy2_r  <= gy_r;
    end
  end

  assign value = val2_r;
  assign gx = gx2_r;
  assign gy = gy2_r;
endmodule

// ===== rtl/core/legendre_2d_basis_with_gradient_unit.sv =====
// Top level: normalized 2D tensor Legendre basis with scaled gradients.
// Each accepted point (xi, eta) yields N result beats, N = basis_order^2 for orders
// 1 to 5 (N = 1 for order 0, 25 above 5), one per cycle while not stalled, k = 1..N
// with tlast on the final one; the input is taken once the index sequencer reaches
// the last index of the previous point. The 1D polynomial pipeline (4 stages) and
// the tensor/gradient pipeline (3 stages) are enabled together and stall as a whole
// when the output register is full and not taken. An accepted point passes the
// point registers and both pipelines before its first result beat.
module legendre_2d_basis_with_gradient_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,     // [17:0] xi, [35:18] eta, zero fill
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [127:0] out_tdata,   // [4:0] basis_index, [25:5] basis_value,
                                    // [73:26] grad_x, [121:74] grad_y, zero fill
  output logic        out_tlast
);
  localparam int D = 7;  // pipeline depth from sequencer to output
  logic [2:0] ord_r;
  logic [31:0] sx_r, sy_r;
  logic [4:0] nmax;
  logic busy_r;
  logic [4:0] k_r;
  logic [4:0] last_k;
  logic en;
  logic [D-1:0] vp_r, lp_r;
  logic [D-1:0][4:0] kp_r;
  logic signed [17:0] xi_r, eta_r;
  leg2d_pkg::leg1d_t rx, ry;
  logic signed [20:0] val;
  logic signed [47:0] gx, gy;
  logic [4:0] kk;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ord_r <= 3'd1; sx_r <= 32'd131072; sy_r <= 32'd131072;
    end else if (cfg_valid) begin
      case (cfg_index)
        leg2d_pkg::REG_ORDER:   ord_r <= cfg_data[2:0];
        leg2d_pkg::REG_SCALE_X: sx_r  <= cfg_data;
        leg2d_pkg::REG_SCALE_Y: sy_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ord_r)
      3'd0, 3'd1: nmax = 5'd1;
      3'd2: nmax = 5'd4;
      3'd3: nmax = 5'd9;
      3'd4: nmax = 5'd16;
      default: nmax = 5'd25;
    endcase
  end
  assign last_k = nmax - 5'd1;

  // global stall: advance when output slot free or taken
  assign en = !out_tvalid || out_tready;
  assign in_tready = en && (!busy_r || k_r == last_k);

  // point capture and index sequencer; points are held through the 1D pipe by
  // keeping xi/eta steady while the sequencer walks indices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; k_r <= '0;
    end else if (en) begin
      if (in_tvalid && in_tready) begin
        busy_r <= 1'b1; k_r <= '0;
        xi_r <= $signed(in_tdata[17:0]);
        eta_r <= $signed(in_tdata[35:18]);
      end else if (busy_r && k_r == last_k) begin
        busy_r <= 1'b0;
      end else if (busy_r) begin
        k_r <= k_r + 5'd1;
      end
    end
  end

  leg2d_poly u_px (.clk, .en, .x(xi_r),  .res(rx));
  leg2d_poly u_py (.clk, .en, .x(eta_r), .res(ry));

  // index metadata: delayed alongside the 1D pipeline stages to meet 1D results, then alongside the tensor stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= '0;
    end else if (en) begin
      vp_r <= {vp_r[D-2:0], busy_r};
      lp_r <= {lp_r[D-2:0], busy_r && k_r == last_k};
      kp_r <= {kp_r[D-2:0], k_r};
    end
  end

  assign kk = kp_r[3];
  leg2d_tens u_t (
    .clk, .en,
    .li(rx.l[leg2d_pkg::deg_i(kk)]), .di(rx.d[leg2d_pkg::deg_i(kk)]),
    .lj(ry.l[leg2d_pkg::deg_j(kk)]), .dj(ry.d[leg2d_pkg::deg_j(kk)]),
    .sx(sx_r), .sy(sy_r), .value(val), .gx(gx), .gy(gy)
  );

  assign out_tvalid = vp_r[D-1];
  assign out_tlast  = lp_r[D-1];
  assign out_tdata  = {6'd0, gy, gx, val, kp_r[D-1] + 5'd1};
endmodule
